### rtl/assert_macros.svh
// Assertion macros used by the grid occupancy map RTL.
// No dependencies; bodies are empty when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
`define GOM_ASSERT(lbl, clk, rst, expr) \
  lbl: assert property (@(posedge clk) disable iff (rst) (expr)) \
    else $error("invariant violated");
`define GOM_ASSERT_IMPL(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("implication violated");
`define GOM_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("next-cycle implication violated");
`else
`define GOM_ASSERT(lbl, clk, rst, expr)
`define GOM_ASSERT_IMPL(lbl, clk, rst, ante, cons)
`define GOM_ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif

`endif

### rtl/gom_pkg.sv
// Package for the grid occupancy map: sizes, command codes, states and the
// token that walks the row cells. No dependencies.
package gom_pkg;

  localparam int MAX_ROWS = 32;
  localparam int MAX_COLS = 32;

  localparam int CNT_W = $clog2(MAX_ROWS + 1);
  localparam int COL_W = $clog2(MAX_COLS + 1);
  // signed working width for start + span and the built sizes
  localparam int SUM_W = 10;

  localparam logic signed [SUM_W-1:0] ZERO_S = '0;
  localparam logic signed [SUM_W-1:0] MAXR_S = SUM_W'(MAX_ROWS);
  localparam logic signed [SUM_W-1:0] MAXC_S = SUM_W'(MAX_COLS);

  typedef enum logic [1:0] {
    CMD_INIT     = 2'd0,
    CMD_SET_ROWS = 2'd1,
    CMD_MARK     = 2'd2,
    CMD_CHECK    = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_HOLD
  } state_t;

  typedef struct packed {
    cmd_t                op;
    logic [CNT_W-1:0]    idx;
    logic [CNT_W-1:0]    lo;
    logic [CNT_W-1:0]    hi;
    logic [MAX_COLS-1:0] mask;
    logic                hit;
  } cell_tok_t;

endpackage

### rtl/gom_if.sv
// Valid/ready channel interfaces for the grid occupancy map.
// No dependencies.
interface gom_req_if;
  logic                valid;
  logic                ready;
  logic [1:0]          command;
  logic signed [7:0]   row_base;
  logic signed [7:0]   col_base;
  logic [5:0]          row_len;
  logic [5:0]          col_len;
  logic [5:0]          new_rows;
  logic [5:0]          new_cols;

  modport source (
    output valid, command, row_base, col_base, row_len, col_len, new_rows, new_cols,
    input  ready
  );
  modport sink (
    input  valid, command, row_base, col_base, row_len, col_len, new_rows, new_cols,
    output ready
  );
endinterface

interface gom_rsp_if;
  logic valid;
  logic ready;
  logic region_free;
  logic size_error;

  modport source (output valid, region_free, size_error, input ready);
  modport sink   (input valid, region_free, size_error, output ready);
endinterface

### rtl/grid_occupancy_map_unit.sv
// Top level of the grid occupancy map: command decode, row-cell chain and
// result register. Depends on gom_pkg, gom_if, gom_cell and assert_macros.svh.
//
// Usage:
//   req carries one command item (init, set row count, mark region, check
//   region) with valid/ready; rsp returns one result item per command with
//   region_free and size_error.
//   A command is decoded on acceptance into a token that walks a chain of
//   MAX_ROWS row cells, one cell per cycle; each cell clears, marks or tests
//   its own row bitmap. The token is registered once at launch and once in
//   each cell; when it leaves the chain the result is registered, then loaded
//   into the rsp output register once that register is free or taken.
//   req is ready only in the idle state, so a new command is not taken until
//   the result of the previous one has been loaded into the output register.
//   A new command may be accepted while the previous result still waits on
//   rsp. If rsp stays stalled when the next result is ready, it is held in a
//   second register and req is not ready until the first is taken.
//   Reset clears every row bitmap and both counts.
module grid_occupancy_map_unit
  import gom_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  gom_req_if.sink      req,
  gom_rsp_if.source    rsp
);

`include "assert_macros.svh"

  state_t state, state_next;

  logic [CNT_W-1:0] active_rows, active_rows_next;
  logic [COL_W-1:0] active_cols, active_cols_next;

  logic              launch_vld;
  cell_tok_t         launch_tok;
  logic [MAX_ROWS:0] chain_vld;
  cell_tok_t         chain_tok [0:MAX_ROWS];

  logic err_q, ok_q, chk_q;
  logic res_free, res_err;
  logic out_vld, out_free, out_err;

  logic accept;
  logic load_out;

  cmd_t                     cmd;
  logic signed [SUM_W-1:0]  rs, cs, rn, cn, re, ce, ar, ac;
  logic signed [SUM_W-1:0]  nr, nc, rows_cl, cols_cl;
  logic signed [SUM_W-1:0]  lo_s, hi_s, mlo, mhi;
  logic                     rows_err, cols_err, err_c, ok_c;
  logic [MAX_COLS-1:0]      mask_c;

  assign cmd = cmd_t'(req.command);
  assign rs  = SUM_W'(req.row_base);
  assign cs  = SUM_W'(req.col_base);
  assign rn  = signed'(SUM_W'(req.row_len));
  assign cn  = signed'(SUM_W'(req.col_len));
  assign nr  = signed'(SUM_W'(req.new_rows));
  assign nc  = signed'(SUM_W'(req.new_cols));
  assign ar  = signed'(SUM_W'(active_rows));
  assign ac  = signed'(SUM_W'(active_cols));
  assign re  = rs + rn;
  assign ce  = cs + cn;

  assign rows_err = nr > MAXR_S;
  assign cols_err = nc > MAXC_S;
  assign rows_cl  = rows_err ? MAXR_S : nr;
  assign cols_cl  = cols_err ? MAXC_S : nc;

  always_comb begin
    lo_s             = ZERO_S;
    hi_s             = ZERO_S;
    mlo              = ZERO_S;
    mhi              = ZERO_S;
    err_c            = 1'b0;
    ok_c             = 1'b0;
    active_rows_next = active_rows;
    active_cols_next = active_cols;
    case (cmd)
      CMD_INIT: begin
        err_c            = rows_err | cols_err;
        active_rows_next = CNT_W'(rows_cl);
        active_cols_next = COL_W'(cols_cl);
      end
      CMD_SET_ROWS: begin
        err_c            = rows_err;
        lo_s             = ar;
        hi_s             = rows_cl;
        active_rows_next = CNT_W'(rows_cl);
      end
      CMD_MARK: begin
        lo_s = (rs < ZERO_S) ? ZERO_S : ((rs > MAXR_S) ? MAXR_S : rs);
        hi_s = (re < ZERO_S) ? ZERO_S : ((re > ar) ? ar : re);
        mlo  = (cs < ZERO_S) ? ZERO_S : ((cs > MAXC_S) ? MAXC_S : cs);
        mhi  = (ce < ZERO_S) ? ZERO_S : ((ce > ac) ? ac : ce);
      end
      CMD_CHECK: begin
        ok_c = (rs >= ZERO_S) && (cs >= ZERO_S) && (re <= ar) && (ce <= ac);
        if (ok_c) begin
          lo_s = rs;
          hi_s = re;
          mlo  = cs;
          mhi  = ce;
        end
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    for (int j = 0; j < MAX_COLS; j++) begin
      mask_c[j] = (signed'(SUM_W'(j)) >= mlo) && (signed'(SUM_W'(j)) < mhi);
    end
  end

  assign accept   = req.valid && req.ready;
  assign load_out = (state == ST_HOLD) && (!out_vld || rsp.ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    req.ready  = 1'b0;
    case (state)
      ST_IDLE: begin
        req.ready = 1'b1;
        if (req.valid) begin
          state_next = ST_RUN;
        end
      end
      ST_RUN: begin
        if (chain_vld[MAX_ROWS]) begin
          state_next = ST_HOLD;
        end
      end
      ST_HOLD: begin
        if (!out_vld || rsp.ready) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active_rows <= '0;
      active_cols <= '0;
      launch_vld  <= 1'b0;
    end else begin
      launch_vld <= accept;
      if (accept) begin
        active_rows <= active_rows_next;
        active_cols <= active_cols_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      launch_tok.op   <= cmd;
      launch_tok.idx  <= '0;
      launch_tok.lo   <= CNT_W'(lo_s);
      launch_tok.hi   <= CNT_W'(hi_s);
      launch_tok.mask <= mask_c;
      launch_tok.hit  <= 1'b0;
      err_q           <= err_c;
      ok_q            <= ok_c;
      chk_q           <= (cmd == CMD_CHECK);
    end
  end

  assign chain_vld[0] = launch_vld;
  assign chain_tok[0] = launch_tok;

  for (genvar g = 0; g < MAX_ROWS; g++) begin : g_cell
    gom_cell u_cell (
      .clk     (clk),
      .rst     (rst),
      .vld_in  (chain_vld[g]),
      .tok_in  (chain_tok[g]),
      .vld_out (chain_vld[g+1]),
      .tok_out (chain_tok[g+1])
    );
  end

  always_ff @(posedge clk) begin
    if (chain_vld[MAX_ROWS]) begin
      res_free <= chk_q && ok_q && !chain_tok[MAX_ROWS].hit;
      res_err  <= err_q;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_vld <= 1'b0;
    end else if (load_out) begin
      out_vld <= 1'b1;
    end else if (rsp.ready) begin
      out_vld <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_free <= res_free;
      out_err  <= res_err;
    end
  end

  assign rsp.valid       = out_vld;
  assign rsp.region_free = out_free;
  assign rsp.size_error  = out_err;

  `GOM_ASSERT(a_one_token, clk, rst, $onehot0(chain_vld))
  `GOM_ASSERT_NEXT(a_launch, clk, rst, accept, chain_vld[0])
  `GOM_ASSERT_IMPL(a_end_in_run, clk, rst, chain_vld[MAX_ROWS], state == ST_RUN)
  `GOM_ASSERT_IMPL(a_excl_flags, clk, rst, rsp.valid, !(rsp.region_free && rsp.size_error))
  `GOM_ASSERT(a_rows_bound, clk, rst, active_rows <= CNT_W'(MAX_ROWS))

endmodule

### rtl/gom_cell.sv
// One row cell of the occupancy chain: holds one row bitmap, acts on the
// passing token and hands it on through a register. Depends on gom_pkg.
module gom_cell
  import gom_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      vld_in,
  input  cell_tok_t tok_in,
  output logic      vld_out,
  output cell_tok_t tok_out
);

  logic [MAX_COLS-1:0] row_bits;
  logic                in_rng;
  logic                busy_hit;
  cell_tok_t           tok_next;

  assign in_rng   = (tok_in.idx >= tok_in.lo) && (tok_in.idx < tok_in.hi);
  assign busy_hit = (tok_in.op == CMD_CHECK) && in_rng && (|(row_bits & tok_in.mask));

  always_ff @(posedge clk) begin
    if (rst) begin
      row_bits <= '0;
    end else if (vld_in) begin
      case (tok_in.op)
        CMD_INIT: begin
          row_bits <= '0;
        end
        CMD_SET_ROWS: begin
          if (in_rng) begin
            row_bits <= '0;
          end
        end
        CMD_MARK: begin
          if (in_rng) begin
            row_bits <= row_bits | tok_in.mask;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld_out <= 1'b0;
    end else begin
      vld_out <= vld_in;
    end
  end

  always_comb begin
    tok_next     = tok_in;
    tok_next.idx = tok_in.idx + CNT_W'(1);
    tok_next.hit = tok_in.hit | busy_hit;
  end

  always_ff @(posedge clk) begin
    tok_out <= tok_next;
  end

endmodule
